FILE: design/bsfh_pkg.sv
// Shared types, constants and functions for the byte stream FNV-1a / fmix64 hash unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bsfh_pkg;

	localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
	localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned FMIX_SHIFT = 33;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MLL  = 5'b00010,
		ST_MHL  = 5'b00100,
		ST_MLH  = 5'b01000,
		ST_MIX  = 5'b10000
	} bsfh_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic hash_upd;  // a word was accepted
		logic finish;    // the accepted word ends a message
		logic empty;     // the accepted word is an empty-message marker
		logic mul_ll;    // low half of value times low half of constant
		logic mul_hl;    // high half of value times low half of constant
		logic mul_lh;    // low half of value times high half of constant
		logic mix;       // xor-shift the finished product
		logic pass;      // 0: first fmix multiply, 1: second
		logic out_load;  // load the result register
	} bsfh_cmd_t;

	// One FNV-1a step. The prime is 2^40 + 0x1b3, and 0x1b3 = 256+128+32+16+2+1.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		begin
			x = {h[63:8], h[7:0] ^ b};
			fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
		end
	endfunction

	function automatic logic [63:0] xor_shift(input logic [63:0] v);
		xor_shift = v ^ (v >> FMIX_SHIFT);
	endfunction

endpackage

FILE: design/bsfh_ctrl.sv
// Controller state machine of the hash unit: handshakes and the fmix64 multiply sequence.
// Depends on bsfh_pkg.
`timescale 1ns / 1ps

module bsfh_ctrl import bsfh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      is_last,
	input  logic      empty_message,
	output logic      out_valid,
	input  logic      out_ready,
	output bsfh_cmd_t cmd
);

	bsfh_state_t state_q, state_d;
	logic        pass_q;
	logic        out_valid_q;
	logic        accept;
	logic        finish;
	logic        out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign finish    = accept && (is_last || empty_message);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_MIX) && pass_q && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (finish) state_d = ST_MLL;
			end
			ST_MLL: state_d = ST_MHL;
			ST_MHL: state_d = ST_MLH;
			ST_MLH: state_d = ST_MIX;
			ST_MIX: begin
				if (!pass_q) state_d = ST_MLL;
				else if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) pass_q <= 1'b0;
			else if (state_q == ST_MIX && !pass_q) pass_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.hash_upd = accept;
		cmd.finish   = finish;
		cmd.empty    = empty_message;
		cmd.mul_ll   = (state_q == ST_MLL);
		cmd.mul_hl   = (state_q == ST_MHL);
		cmd.mul_lh   = (state_q == ST_MLH);
		cmd.mix      = (state_q == ST_MIX);
		cmd.pass     = pass_q;
		cmd.out_load = out_load;
	end

endmodule

FILE: design/bsfh_dp.sv
// Datapath of the hash unit: running FNV-1a value, shared 32x32 multiplier and result register.
// Depends on bsfh_pkg.
`timescale 1ns / 1ps

module bsfh_dp import bsfh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bsfh_cmd_t   cmd,
	input  logic [7:0]  data_byte,
	output logic [63:0] hash_value
);

	logic [63:0] hash_q;
	logic [63:0] fx_q;
	logic [63:0] acc_q;
	logic [63:0] out_q;
	logic [63:0] hash_next;
	logic [63:0] konst;
	logic [31:0] op_a;
	logic [31:0] op_c;
	logic [63:0] prod;

	assign hash_next = fnv_step(hash_q, data_byte);
	assign konst     = cmd.pass ? FMIX_C2 : FMIX_C1;
	assign op_a      = cmd.mul_hl ? fx_q[63:32] : fx_q[31:0];
	assign op_c      = cmd.mul_lh ? konst[63:32] : konst[31:0];
	assign prod      = {32'd0, op_a} * {32'd0, op_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (cmd.hash_upd) begin
			hash_q <= cmd.finish ? FNV_BASIS : hash_next;
		end
	end

	// Product modulo 2^64 from three partial products; the high-by-high term drops out.
	always_ff @(posedge clk) begin
		if (cmd.finish) fx_q <= xor_shift(cmd.empty ? FNV_BASIS : hash_next);
		else if (cmd.mix && !cmd.pass) fx_q <= xor_shift(acc_q);
		if (cmd.mul_ll) acc_q <= prod;
		else if (cmd.mul_hl || cmd.mul_lh) acc_q <= acc_q + {prod[31:0], 32'd0};
		if (cmd.out_load) out_q <= xor_shift(acc_q);
	end

	assign hash_value = out_q;

endmodule

FILE: design/byte_stream_fnv1a_fmix_hash_unit.sv
// Byte stream hash: FNV-1a 64 over the message words, MurmurHash3 fmix64 on the final value.
// Throughput: one message word per cycle while idle; a word that ends a message (or an
// empty-message marker) occupies the unit through the two fmix64 multiplies, which share one
// 32x32 multiplier over three partial products each, each followed by an xor-shift state.
// The hash is loaded in the second MIX state, once any previous hash has been taken.
// Reset: arst_n clears the handshake state and reloads the running value with the FNV basis.
`timescale 1ns / 1ps

module byte_stream_fnv1a_fmix_hash_unit import bsfh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel: one message word per transfer.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	input  logic        empty_message,
	// Output channel: one hash per finished message.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value
);

	bsfh_cmd_t cmd;

	// The controller accepts ordinary words every cycle while idle, even while a finished
	// hash waits in the output register; only the final xor-shift waits for that register.
	bsfh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.is_last       (is_last),
		.empty_message (empty_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cmd           (cmd)
	);

	// The datapath holds the running value, the fmix64 working value and the result.
	bsfh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.hash_value (hash_value)
	);

endmodule
